FILE: rtl/mavg_pkg.sv
// shared constants, sequencer states and defaults for the moving average filter
package mavg_pkg;

    // default sizing of the delay line and sample width
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // window length register
    localparam int              WIN_REG_BITS = 7;
    localparam logic [6:0]      WIN_RESET    = 7'd8;

    // width of the average result
    localparam int AVG_BITS = 16;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/moving_average_filter_top.sv
// boxcar moving average filter: delay-line memory, running sum and divider
//
// Input channel: sample and block_start, transferred when in_valid is high and
// in_stall is low. A sample with block_start set empties the window and is the
// first sample of the new one. Output channel: average, transferred when
// out_valid is high and out_stall is low.
// Once window_length samples of the current block have arrived, each sample
// gives one average (sum of the last window_length samples divided by
// window_length, truncated); earlier samples give nothing.
// One item at a time: the transfer reads the delay line (synchronous RAM), the
// sum state writes the sample and updates the sum, then a bit-serial divide of
// SUM_BITS quotient bits, the divide state sees it finish and the output state
// loads the output register; a sample without a result returns to idle after
// the sum state.
// The output register holds a finished average while the receiver stalls; the
// next sample is still taken and worked on, and waits only to load its result.
// Writing window_length (cfg_we, cfg_wdata) restarts the window; write only
// while idle. Reset clears the sum, fill count and pointer and sets the
// window to 8; the delay line is not cleared and needs no clearing pass.
module moving_average_filter_top
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_BITS-1:0]  sample,
    input  logic                    block_start,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [AVG_BITS-1:0]     average,
    input  logic                    cfg_we,
    input  logic [WIN_REG_BITS-1:0] cfg_wdata
);

    localparam int PTR_BITS = $clog2(MAX_WINDOW);
    localparam int W_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int DIF_BITS = W_BITS + 1;
    localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
    localparam int ADD_BITS = SUM_BITS + 1;
    localparam int CMP_BITS = (W_BITS > WIN_REG_BITS) ? W_BITS : WIN_REG_BITS;

    state_t                  state_reg, state_next;
    logic [WIN_REG_BITS-1:0] win_reg, win_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic [W_BITS-1:0]       fill_reg, fill_next;
    logic [PTR_BITS-1:0]     wp_reg, wp_next;
    logic [SAMPLE_BITS-1:0]  smp_reg;
    logic                    blk_reg;
    logic [SAMPLE_BITS-1:0]  rd_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [AVG_BITS-1:0]     average_reg;

    logic [SAMPLE_BITS-1:0]  dline_mem [MAX_WINDOW];

    logic [CMP_BITS-1:0]     win_ext, win_clip;
    logic [W_BITS-1:0]       win_eff;
    logic [DIF_BITS-1:0]     wp_x, w_x;
    logic [PTR_BITS-1:0]     rd_addr;
    logic                    in_xfer, out_xfer;
    logic [W_BITS-1:0]       fill_base, fill_upd;
    logic [SUM_BITS-1:0]     sum_base, sum_upd;
    logic [ADD_BITS-1:0]     sum_add;
    logic                    full;
    logic                    has_result;
    logic                    dl_we;
    logic                    div_start;
    logic                    div_done;
    logic [SUM_BITS-1:0]     div_quo;
    logic                    load_out;

    // window length clipped to 1..MAX_WINDOW
    always_comb
    begin
        win_ext = CMP_BITS'(win_reg);
        if (win_ext == '0)
            win_clip = CMP_BITS'(1);
        else if (win_ext > CMP_BITS'(MAX_WINDOW))
            win_clip = CMP_BITS'(MAX_WINDOW);
        else
            win_clip = win_ext;
        win_eff = W_BITS'(win_clip);
    end

    // slot written window-length samples ago
    always_comb
    begin
        wp_x = DIF_BITS'(wp_reg);
        w_x  = DIF_BITS'(win_eff);
        if (wp_x >= w_x)
            rd_addr = PTR_BITS'(wp_x - w_x);
        else
            rd_addr = PTR_BITS'(wp_x + DIF_BITS'(MAX_WINDOW) - w_x);
    end

    // input taken only while idle
    assign in_stall = (state_reg != ST_IDLE);

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    // running sum and fill update for the sample in hand
    always_comb
    begin
        fill_base  = blk_reg ? '0 : fill_reg;
        sum_base   = blk_reg ? '0 : sum_reg;
        full       = (fill_base >= win_eff);
        fill_upd   = full ? fill_base : fill_base + W_BITS'(1);
        sum_add    = ADD_BITS'(sum_base) + ADD_BITS'(smp_reg);
        if (full)
            sum_upd = SUM_BITS'(sum_add - ADD_BITS'(rd_data_reg));
        else
            sum_upd = SUM_BITS'(sum_add);
        has_result = (fill_upd >= win_eff);
    end

    // sequencer: next state and control
    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        wp_next        = wp_reg;
        dl_we          = 1'b0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_xfer;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                dl_we     = 1'b1;
                sum_next  = sum_upd;
                fill_next = fill_upd;
                wp_next   = (wp_reg == PTR_BITS'(MAX_WINDOW - 1)) ? '0
                                                                  : wp_reg + PTR_BITS'(1);
                if (has_result)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_xfer)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // register write restarts the window
        if (cfg_we)
        begin
            win_next  = cfg_wdata;
            sum_next  = '0;
            fill_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= WIN_RESET;
            sum_reg       <= '0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // captured sample and output data
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            smp_reg <= sample;
            blk_reg <= block_start;
        end
        if (load_out)
            average_reg <= AVG_BITS'(div_quo);
    end

    // delay line: write the new sample, read the outgoing one on transfer
    always_ff @(posedge clk)
    begin
        if (dl_we)
            dline_mem[wp_reg] <= smp_reg;
        if (in_xfer)
            rd_data_reg <= dline_mem[rd_addr];
    end

    // sum divided by window length
    mavg_div #(
        .DVD_BITS (SUM_BITS),
        .DVS_BITS (W_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_upd),
        .divisor  (win_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    // checks
    a_xfer_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_SUM)
        else $error("transfer did not move to sum update");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_eff)
        else $error("fill count above window length");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == '0 |-> sum_reg == '0)
        else $error("non-zero sum with empty window");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg || !out_stall)
        else $error("output register overwritten while stalled");

endmodule

FILE: rtl/mavg_div.sv
// restoring divider, one quotient bit per cycle
module mavg_div #(
    parameter int DVD_BITS = 22,
    parameter int DVS_BITS = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0] divisor,
    output logic                done,
    output logic [DVD_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DVD_BITS + 1);

    logic [DVD_BITS-1:0] quo_reg, quo_next;
    logic [DVS_BITS-1:0] rem_reg, rem_next;
    logic [DVS_BITS-1:0] dvs_reg, dvs_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DVS_BITS:0]   trial;
    logic                ge;

    // one restoring step: bring down the next dividend bit and try a subtract
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_BITS-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_BITS'(DVD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_BITS-2:0], ge};
            rem_next = ge ? DVS_BITS'(trial - {1'b0, dvs_reg}) : DVS_BITS'(trial);
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: verif/moving_average_filter_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the boxcar moving average filter top level
module moving_average_filter_top_tb;
    import mavg_pkg::*;

    localparam int WINDOW_MAX   = MAX_WINDOW_DEF;
    localparam int SBITS        = SAMPLE_BITS_DEF;
    localparam int PTR_W        = $clog2(WINDOW_MAX);
    localparam int FILL_W       = PTR_W + 1;
    localparam int SUM_W        = SBITS + PTR_W;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 125;
    localparam int NUM_PHASES   = 12;

    typedef struct packed {
        logic [SBITS-1:0] sample;
        logic             block_start;
    } sample_item_t;

    // block ports
    logic                    clk;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic [SBITS-1:0]        sample      = '0;
    logic                    block_start = 1'b0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [AVG_BITS-1:0]     average;
    logic                    cfg_we      = 1'b0;
    logic [WIN_REG_BITS-1:0] cfg_wdata   = '0;

    // traffic shaping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatches     = 0;

    sample_item_t        pending_samples[$];
    logic [AVG_BITS-1:0] avg_expected[$];

    // predictor state: window register, delay line, running sum, fill and pointer
    logic [WIN_REG_BITS-1:0] win_len    = WIN_RESET;
    logic [SBITS-1:0]        taps [WINDOW_MAX];
    logic [SUM_W-1:0]        window_sum = '0;
    logic [FILL_W-1:0]       fill       = '0;
    logic [PTR_W-1:0]        wptr       = '0;

    moving_average_filter_top #(
        .MAX_WINDOW  (WINDOW_MAX),
        .SAMPLE_BITS (SBITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .block_start (block_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .average     (average),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // window length as used: zero counts as one, large values clip to the delay line
    function automatic int unsigned eff_window(input logic [WIN_REG_BITS-1:0] w);
        if (w == 0)
            return 1;
        if (w > WINDOW_MAX)
            return WINDOW_MAX;
        return w;
    endfunction

    // advance the window by one sample; returns 1 when an average is due
    function automatic bit predict_average(input sample_item_t it,
                                           output logic [AVG_BITS-1:0] avg);
        int unsigned      w;
        logic [SUM_W:0]   acc;
        logic [PTR_W-1:0] old_idx;
        w = eff_window(win_len);
        if (it.block_start)
        begin
            window_sum = '0;
            fill       = '0;
        end
        acc = {1'b0, window_sum} + it.sample;
        if (fill >= w)
        begin
            // oldest sample of a full window drops out
            old_idx = wptr - PTR_W'(w);
            acc     = acc - taps[old_idx];
        end
        else
        begin
            fill = fill + 1'b1;
        end
        taps[wptr] = it.sample;
        wptr       = wptr + 1'b1;
        window_sum = acc[SUM_W-1:0];
        avg        = AVG_BITS'(window_sum / w);
        return fill >= w;
    endfunction

    // sample values weighted towards the extremes
    function automatic logic [SBITS-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return SBITS'($urandom_range(65535, 65280));
            3:       return SBITS'($urandom_range(255));
            default: return SBITS'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic bs, input logic [SBITS-1:0] s);
        sample_item_t it;
        it.sample      = s;
        it.block_start = bs;
        pending_samples.push_back(it);
    endtask

    // mostly whole blocks that fill the window, some cut short, odd restarts inside
    task automatic queue_phase(input int unsigned w, input int n);
        int           count;
        int           len;
        sample_item_t it;
        count = 0;
        while (count < n)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(w, 1);
            else
                len = w + $urandom_range(w + 16, 0);
            for (int i = 0; i < len && count < n; i++)
            begin
                if (i == 0)
                    it.block_start = ($urandom_range(7) != 0);
                else
                    it.block_start = ($urandom_range(63) == 0);
                it.sample = pick_sample();
                pending_samples.push_back(it);
                count++;
            end
        end
    endtask

    // sender holds off until every average is in and the block has gone quiet
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || avg_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_window(input logic [WIN_REG_BITS-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // input driver: offer the next pending item once the last one has transferred
    always @(posedge clk)
    begin : driver
        sample_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt          = pending_samples.pop_front();
                in_valid    <= 1'b1;
                sample      <= nxt.sample;
                block_start <= nxt.block_start;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output side: random stall, or a long hold when one is requested
    always @(posedge clk)
    begin : receiver
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_request)
        begin
            hold_served <= hold_request;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // predict on each input transfer, compare each output transfer
    always @(posedge clk)
    begin : average_check
        logic [AVG_BITS-1:0] avg_pred;
        logic [AVG_BITS-1:0] avg_want;
        sample_item_t        got_in;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                win_len    = cfg_wdata;
                window_sum = '0;
                fill       = '0;
            end
            if (in_valid && !in_stall)
            begin
                got_in.sample      = sample;
                got_in.block_start = block_start;
                if (predict_average(got_in, avg_pred))
                    avg_expected.push_back(avg_pred);
            end
            if (out_valid && !out_stall)
            begin
                if (avg_expected.size() == 0)
                begin
                    $error("average: expected none, actual %0d", average);
                    mismatches++;
                end
                else
                begin
                    avg_want = avg_expected.pop_front();
                    if (average !== avg_want)
                    begin
                        $error("average mismatch: expected %0d, actual %0d", avg_want, average);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("moving_average_filter_top verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial
    begin : stimulus
        logic [WIN_REG_BITS-1:0] phase_win [NUM_PHASES];
        int                      phase_send [NUM_PHASES];
        int                      phase_recv [NUM_PHASES];

        phase_win  = '{7'd1, 7'd64, 7'd5, 7'd127, 7'd3, 7'd65, 7'd2, 7'd63,
                       7'($urandom_range(16)), 7'($urandom_range(127)), 7'd0,
                       7'($urandom_range(127))};
        phase_send = '{0, 0, 87, 87, 0, 0, 24, 24, 0, 87, 0, 24};
        phase_recv = '{0, 0, 0, 0, 87, 87, 24, 24, 0, 0, 87, 24};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset window of eight: full scale, falling to zero, restart mid-stream
        repeat (8) push_item(1'b0, '1);
        repeat (3) push_item(1'b0, '0);
        push_item(1'b1, 16'h1234);
        repeat (7) push_item(1'b0, 16'h0001);
        wait_drained();

        // zero window length behaves as one
        write_window(7'd0);
        push_item(1'b0, '0);
        push_item(1'b0, '1);
        push_item(1'b1, 16'hA5A5);
        wait_drained();

        // window of two, first sample after a restart gives nothing
        write_window(7'd2);
        push_item(1'b1, 16'h8000);
        push_item(1'b0, 16'h7FFF);
        push_item(1'b0, 16'h5555);
        wait_drained();

        // random phases over window settings and traffic patterns
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_window(phase_win[p]);
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            queue_phase(eff_window(phase_win[p]), PHASE_ITEMS);
            // back the block up against a long output hold
            if (p == 0)
                hold_request++;
            wait_drained();
        end

        if (mismatches == 0)
            $display("moving_average_filter_top verification clean");
        else
            $display("moving_average_filter_top verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/mavg_pkg.sv
rtl/mavg_div.sv
rtl/moving_average_filter_top.sv
verif/moving_average_filter_top_tb.sv
